FILE: rtl/core/polyline_corner_smoothing_assert.svh
// assertion macros shared by the polyline corner smoothing rtl
`ifndef POLYLINE_CORNER_SMOOTHING_ASSERT_SVH
`define POLYLINE_CORNER_SMOOTHING_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PCS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pcs_pkg.sv
// types, constants and helpers for the polyline corner smoothing block
`default_nettype none

package pcs_pkg;

  localparam int COORD_W = 32;
  localparam int MAG_W = COORD_W + 1;      // |difference| and |sum of three|
  localparam int LIMB_W = 34;              // multiplier operand width
  localparam int PROD_W = 2 * LIMB_W;
  localparam int P_W = 2 * COORD_W + 1;    // one coordinate product
  localparam int N_W = P_W + 1;            // squared length, dot magnitude
  localparam int M_W = 2 * N_W - 1;        // product of squared lengths
  localparam int MX_W = 4 * LIMB_W;        // limb view of that product
  localparam int COS_SQ_W = 17;
  localparam int Q16_SHIFT = 16;
  localparam int ACC_W = M_W + COS_SQ_W + 1;

  // floor(n / 3) = (n * RCP3) >> RCP3_SHIFT, exact for n < 2**RCP3_SHIFT
  localparam int RCP3_SHIFT = 33;
  localparam logic [31:0] RCP3 = 32'd2863311531;

  localparam logic [COS_SQ_W-1:0] COS_SQ_RESET = 17'd42894;

  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_LSB = 2;
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_COS_SQ = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      was_smoothed;
    logic                      last_of_line;
  } result_t;

  typedef struct packed {
    logic                enable;
    logic [COS_SQ_W-1:0] cos_sq;
  } cfg_t;

  typedef struct packed {
    logic       mul_en;
    logic       acc_en;
    logic       load;
    logic [1:0] shift;
  } mac_ctrl_t;

  function automatic logic [MAG_W-1:0] diff_mag(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic [MAG_W-1:0] sum_mag(input logic signed [MAG_W:0] v);
    return v[MAG_W] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcs_if.sv
// point and result stream interfaces
`default_nettype none

interface pcs_in_if ();
  logic                               valid;
  logic                               ready;
  logic signed [pcs_pkg::COORD_W-1:0] point_x;
  logic signed [pcs_pkg::COORD_W-1:0] point_y;
  logic                               end_of_line;

  modport source (output valid, point_x, point_y, end_of_line, input ready);
  modport sink (input valid, point_x, point_y, end_of_line, output ready);
endinterface

interface pcs_out_if ();
  logic                               valid;
  logic                               ready;
  logic signed [pcs_pkg::COORD_W-1:0] out_x;
  logic signed [pcs_pkg::COORD_W-1:0] out_y;
  logic                               was_smoothed;
  logic                               last_of_line;

  modport source (output valid, out_x, out_y, was_smoothed, last_of_line, input ready);
  modport sink (input valid, out_x, out_y, was_smoothed, last_of_line, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pcs_mac.sv
// shared 34x34 multiplier with shifted accumulator
`default_nettype none

module pcs_mac (
  input  logic                            clk_i,
  input  pcs_pkg::mac_ctrl_t              ctrl_i,
  input  logic [pcs_pkg::LIMB_W-1:0]      op_a_i,
  input  logic [pcs_pkg::LIMB_W-1:0]      op_b_i,
  output logic [pcs_pkg::ACC_W-1:0]       acc_o
);

  logic [pcs_pkg::PROD_W-1:0] prod_q;
  logic [pcs_pkg::ACC_W-1:0]  acc_q;
  logic [pcs_pkg::ACC_W-1:0]  acc_d;
  logic [pcs_pkg::ACC_W-1:0]  addend;

  // product is registered before it meets the adder
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= pcs_pkg::PROD_W'(op_a_i) * pcs_pkg::PROD_W'(op_b_i);
    end
  end

  always_comb begin
    case (ctrl_i.shift)
      2'd0:    addend = pcs_pkg::ACC_W'(prod_q);
      2'd1:    addend = pcs_pkg::ACC_W'(prod_q) << pcs_pkg::LIMB_W;
      2'd2:    addend = pcs_pkg::ACC_W'(prod_q) << (2 * pcs_pkg::LIMB_W);
      default: addend = pcs_pkg::ACC_W'(prod_q) << (3 * pcs_pkg::LIMB_W);
    endcase
    acc_d = (ctrl_i.load ? '0 : acc_q) + addend;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

FILE: rtl/core/pcs_cfg.sv
// apb configuration registers
`default_nettype none

module pcs_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [pcs_pkg::APB_ADDR_W-1:0]    paddr_i,
  input  logic [31:0]                       pwdata_i,
  output logic [31:0]                       prdata_o,
  output logic                              pready_o,
  output pcs_pkg::cfg_t                     cfg_o
);

  pcs_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic          reg_idx;

  assign reg_idx  = paddr_i[pcs_pkg::REG_IDX_LSB];
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable <= 1'b1;
      cfg_q.cos_sq <= pcs_pkg::COS_SQ_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        pcs_pkg::REG_ENABLE: cfg_q.enable <= pwdata_i[0];
        pcs_pkg::REG_COS_SQ: cfg_q.cos_sq <= pwdata_i[pcs_pkg::COS_SQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pcs_pkg::REG_ENABLE: prdata_o = 32'(cfg_q.enable);
      pcs_pkg::REG_COS_SQ: prdata_o = 32'(cfg_q.cos_sq);
      default:             prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/pcs_out_fifo.sv
// two-entry result queue in front of the output channel
`default_nettype none

module pcs_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pcs_pkg::result_t  push_data_i,
  output logic              full_o,
  pcs_out_if.source         res_o
);

  localparam int Depth = 2;
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  pcs_pkg::result_t entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             pop;

  assign pop    = res_o.valid && res_o.ready;
  assign full_o = (count_q == CntW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign res_o.valid        = (count_q != '0);
  assign res_o.out_x        = entry_q[rd_ptr_q].out_x;
  assign res_o.out_y        = entry_q[rd_ptr_q].out_y;
  assign res_o.was_smoothed = entry_q[rd_ptr_q].was_smoothed;
  assign res_o.last_of_line = entry_q[rd_ptr_q].last_of_line;

endmodule

`default_nettype wire

FILE: rtl/core/polyline_corner_smoothing.sv
// polyline corner smoothing top level: sequencer, point registers, datapath
//
// Points of a polyline enter on in_i one item at a time, end_of_line on the
// last one. Results leave on res_o through a two-entry queue, so a finished
// result may wait there while the next point is taken. The first and last
// point of every polyline come out unchanged; an interior point comes out
// when its successor arrives, either as is or as the truncated mean of
// itself and its neighbors when the turn at it is gentle enough.
// Configuration (enable, cos^2 threshold in Q16) sits on the APB port at
// byte addresses 0 and 4. The user must see that it is written only while
// the block is idle; the block itself does not enforce this. An interior
// point with smoothing on runs twenty products through the one shared
// 34x34 multiplier, each in a multiply phase and then an accumulate phase.
// First points, points that end a short line and smoothing-off items skip
// the multiplier program. A released result goes from an emit state into
// the queue and turns valid on res_o once the queue has registered it.
// in_i.ready is high only while the sequencer is idle. If res_o stalls and
// the queue fills, the sequencer holds in its emit state; nothing is lost.
// Reset (rst_ni low, asynchronous) empties the queue, restarts at the start
// of a polyline and restores the configuration defaults.
`default_nettype none
`include "polyline_corner_smoothing_assert.svh"

module polyline_corner_smoothing (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pcs_in_if.sink                         in_i,
  pcs_out_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int CW = pcs_pkg::COORD_W;
  localparam int MW = pcs_pkg::MAG_W;
  localparam int LW = pcs_pkg::LIMB_W;
  localparam int PW = pcs_pkg::P_W;
  localparam int NW = pcs_pkg::N_W;
  localparam int AW = pcs_pkg::ACC_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIFF   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_EMIT_A = 3'd4;
  localparam logic [2:0] ST_EMIT_B = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  // multiplier program; results are picked up from the accumulator at the
  // multiply phase of the following step, the last result in ST_DECIDE
  localparam logic [4:0] STEP_P1  = 5'd0;   // |ax|*|bx|
  localparam logic [4:0] STEP_P2  = 5'd1;   // |ay|*|by|
  localparam logic [4:0] STEP_N1A = 5'd2;   // ax^2
  localparam logic [4:0] STEP_N1B = 5'd3;   // + ay^2
  localparam logic [4:0] STEP_N2A = 5'd4;   // bx^2
  localparam logic [4:0] STEP_N2B = 5'd5;   // + by^2
  localparam logic [4:0] STEP_QX  = 5'd6;   // |sum x| / 3
  localparam logic [4:0] STEP_QY  = 5'd7;   // |sum y| / 3
  localparam logic [4:0] STEP_M0  = 5'd8;   // |v1|^2 * |v2|^2, four limbs
  localparam logic [4:0] STEP_M1  = 5'd9;
  localparam logic [4:0] STEP_M2  = 5'd10;
  localparam logic [4:0] STEP_M3  = 5'd11;
  localparam logic [4:0] STEP_L0  = 5'd12;  // dot^2, four limbs
  localparam logic [4:0] STEP_L1  = 5'd13;
  localparam logic [4:0] STEP_L2  = 5'd14;
  localparam logic [4:0] STEP_L3  = 5'd15;
  localparam logic [4:0] STEP_R0  = 5'd16;  // threshold * M, four limbs
  localparam logic [4:0] STEP_R1  = 5'd17;
  localparam logic [4:0] STEP_R2  = 5'd18;
  localparam logic [4:0] STEP_R3  = 5'd19;
  localparam logic [4:0] STEP_LAST = STEP_R3;

  pcs_pkg::cfg_t      cfg;
  pcs_pkg::mac_ctrl_t mac_ctrl;
  pcs_pkg::result_t   push_data;
  logic [LW-1:0]      op_a;
  logic [LW-1:0]      op_b;
  logic [AW-1:0]      acc;
  logic               push;
  logic               fifo_full;
  logic               in_fire;

  logic [2:0] state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       phase_q, phase_d;
  logic [1:0] seen_q;

  // original points: before the held one, the held one, the new arrival
  logic signed [CW-1:0] older_x_q, older_y_q;
  logic signed [CW-1:0] held_x_q, held_y_q;
  logic signed [CW-1:0] new_x_q, new_y_q;
  logic                 eol_q;

  // segment vectors and neighbor sums as magnitude and sign
  logic [MW-1:0] ax_mag_q, ay_mag_q, bx_mag_q, by_mag_q;
  logic          ax_neg_q, ay_neg_q, bx_neg_q, by_neg_q;
  logic [MW-1:0] sx_mag_q, sy_mag_q;
  logic          sx_neg_q, sy_neg_q;

  logic [PW-1:0]            p1_q, p2_q;
  logic [NW-1:0]            n1_q, n2_q;
  logic [NW-1:0]            dmag_q;
  logic                     dneg_q;
  logic signed [CW-1:0]     qx_q, qy_q;
  logic [pcs_pkg::M_W-1:0]  m_q;
  logic [pcs_pkg::M_W-1:0]  l_q;
  logic                     smooth_q;

  logic signed [MW-1:0] ax_s, ay_s, bx_s, by_s;
  logic signed [MW:0]   sx_s, sy_s;
  logic [NW-1:0]        dmag_c;
  logic                 dneg_c;
  logic                 smooth_c;
  logic [CW-1:0]        quot;
  logic [pcs_pkg::MX_W-1:0] m_ext;

  pcs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  pcs_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  pcs_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .res_o       (res_o)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    phase_d = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (seen_q == 2'd0) begin
            state_d = ST_EMIT_B;
          end else if (seen_q == 2'd1) begin
            state_d = in_i.end_of_line ? ST_EMIT_B : ST_DONE;
          end else if (cfg.enable) begin
            state_d = ST_DIFF;
          end else begin
            state_d = ST_EMIT_A;
          end
        end
      end
      ST_DIFF: begin
        state_d = ST_MUL;
        step_d  = STEP_P1;
        phase_d = 1'b0;
      end
      ST_MUL: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          if (step_q == STEP_LAST) begin
            state_d = ST_DECIDE;
          end else begin
            step_d = step_q + 5'd1;
          end
        end
      end
      ST_DECIDE: state_d = ST_EMIT_A;
      ST_EMIT_A: begin
        if (!fifo_full) begin
          state_d = eol_q ? ST_EMIT_B : ST_DONE;
        end
      end
      ST_EMIT_B: begin
        if (!fifo_full) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_P1;
      phase_q <= 1'b0;
      seen_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      // polyline position advances once the item is fully handled
      if (state_q == ST_DONE) begin
        if (eol_q) begin
          seen_q <= 2'd0;
        end else begin
          seen_q <= (seen_q == 2'd0) ? 2'd1 : 2'd2;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // multiplier program decode
  // ---------------------------------------------------------------------
  assign m_ext = pcs_pkg::MX_W'(m_q);

  always_comb begin
    mac_ctrl.mul_en = (state_q == ST_MUL) && !phase_q;
    mac_ctrl.acc_en = (state_q == ST_MUL) && phase_q;
    mac_ctrl.load   = 1'b0;
    mac_ctrl.shift  = 2'd0;
    op_a            = '0;
    op_b            = '0;
    case (step_q)
      STEP_P1: begin
        op_a = LW'(ax_mag_q); op_b = LW'(bx_mag_q); mac_ctrl.load = 1'b1;
      end
      STEP_P2: begin
        op_a = LW'(ay_mag_q); op_b = LW'(by_mag_q); mac_ctrl.load = 1'b1;
      end
      STEP_N1A: begin
        op_a = LW'(ax_mag_q); op_b = LW'(ax_mag_q); mac_ctrl.load = 1'b1;
      end
      STEP_N1B: begin
        op_a = LW'(ay_mag_q); op_b = LW'(ay_mag_q);
      end
      STEP_N2A: begin
        op_a = LW'(bx_mag_q); op_b = LW'(bx_mag_q); mac_ctrl.load = 1'b1;
      end
      STEP_N2B: begin
        op_a = LW'(by_mag_q); op_b = LW'(by_mag_q);
      end
      STEP_QX: begin
        op_a = LW'(sx_mag_q); op_b = LW'(pcs_pkg::RCP3); mac_ctrl.load = 1'b1;
      end
      STEP_QY: begin
        op_a = LW'(sy_mag_q); op_b = LW'(pcs_pkg::RCP3); mac_ctrl.load = 1'b1;
      end
      STEP_M0: begin
        op_a = n1_q[LW-1:0]; op_b = n2_q[LW-1:0]; mac_ctrl.load = 1'b1;
      end
      STEP_M1: begin
        op_a = n1_q[LW-1:0]; op_b = LW'(n2_q[NW-1:LW]); mac_ctrl.shift = 2'd1;
      end
      STEP_M2: begin
        op_a = LW'(n1_q[NW-1:LW]); op_b = n2_q[LW-1:0]; mac_ctrl.shift = 2'd1;
      end
      STEP_M3: begin
        op_a = LW'(n1_q[NW-1:LW]); op_b = LW'(n2_q[NW-1:LW]); mac_ctrl.shift = 2'd2;
      end
      STEP_L0: begin
        op_a = dmag_q[LW-1:0]; op_b = dmag_q[LW-1:0]; mac_ctrl.load = 1'b1;
      end
      STEP_L1: begin
        op_a = dmag_q[LW-1:0]; op_b = LW'(dmag_q[NW-1:LW]); mac_ctrl.shift = 2'd1;
      end
      STEP_L2: begin
        op_a = LW'(dmag_q[NW-1:LW]); op_b = dmag_q[LW-1:0]; mac_ctrl.shift = 2'd1;
      end
      STEP_L3: begin
        op_a = LW'(dmag_q[NW-1:LW]); op_b = LW'(dmag_q[NW-1:LW]);
        mac_ctrl.shift = 2'd2;
      end
      STEP_R0: begin
        op_a = LW'(cfg.cos_sq); op_b = m_ext[0 +: LW]; mac_ctrl.load = 1'b1;
      end
      STEP_R1: begin
        op_a = LW'(cfg.cos_sq); op_b = m_ext[LW +: LW]; mac_ctrl.shift = 2'd1;
      end
      STEP_R2: begin
        op_a = LW'(cfg.cos_sq); op_b = m_ext[2*LW +: LW]; mac_ctrl.shift = 2'd2;
      end
      STEP_R3: begin
        op_a = LW'(cfg.cos_sq); op_b = m_ext[3*LW +: LW]; mac_ctrl.shift = 2'd3;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // datapath arithmetic outside the multiplier
  // ---------------------------------------------------------------------
  assign ax_s = MW'(held_x_q) - MW'(older_x_q);
  assign ay_s = MW'(held_y_q) - MW'(older_y_q);
  assign bx_s = MW'(new_x_q) - MW'(held_x_q);
  assign by_s = MW'(new_y_q) - MW'(held_y_q);
  assign sx_s = (MW + 1)'(older_x_q) + (MW + 1)'(held_x_q) + (MW + 1)'(new_x_q);
  assign sy_s = (MW + 1)'(older_y_q) + (MW + 1)'(held_y_q) + (MW + 1)'(new_y_q);

  // dot product from the two signed partial products; a zero product has no sign
  always_comb begin
    logic f1;
    logic f2;
    f1 = (ax_neg_q ^ bx_neg_q) && (p1_q != '0);
    f2 = (ay_neg_q ^ by_neg_q) && (p2_q != '0);
    if (f1 == f2) begin
      dmag_c = NW'(p1_q) + NW'(p2_q);
      dneg_c = f1;
    end else if (p1_q >= p2_q) begin
      dmag_c = NW'(p1_q) - NW'(p2_q);
      dneg_c = f1;
    end else begin
      dmag_c = NW'(p2_q) - NW'(p1_q);
      dneg_c = f2;
    end
  end

  // gentle turn: zero-length segment, positive dot, or squared compare
  always_comb begin
    if (n1_q == '0 || n2_q == '0) begin
      smooth_c = 1'b1;
    end else if (dmag_q == '0) begin
      smooth_c = (cfg.cos_sq != '0);
    end else if (!dneg_q) begin
      smooth_c = 1'b1;
    end else begin
      smooth_c = (AW'({l_q, {pcs_pkg::Q16_SHIFT{1'b0}}}) < acc);
    end
  end

  assign quot = acc[pcs_pkg::RCP3_SHIFT +: CW];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      new_x_q  <= in_i.point_x;
      new_y_q  <= in_i.point_y;
      eol_q    <= in_i.end_of_line;
      smooth_q <= 1'b0;
    end
    if (state_q == ST_DIFF) begin
      ax_mag_q <= pcs_pkg::diff_mag(ax_s);
      ay_mag_q <= pcs_pkg::diff_mag(ay_s);
      bx_mag_q <= pcs_pkg::diff_mag(bx_s);
      by_mag_q <= pcs_pkg::diff_mag(by_s);
      ax_neg_q <= ax_s[MW-1];
      ay_neg_q <= ay_s[MW-1];
      bx_neg_q <= bx_s[MW-1];
      by_neg_q <= by_s[MW-1];
      sx_mag_q <= pcs_pkg::sum_mag(sx_s);
      sy_mag_q <= pcs_pkg::sum_mag(sy_s);
      sx_neg_q <= sx_s[MW];
      sy_neg_q <= sy_s[MW];
    end
    if (state_q == ST_MUL && !phase_q) begin
      case (step_q)
        STEP_P2:  p1_q <= acc[PW-1:0];
        STEP_N1A: p2_q <= acc[PW-1:0];
        STEP_N1B: begin
          dmag_q <= dmag_c;
          dneg_q <= dneg_c;
        end
        STEP_N2A: n1_q <= acc[NW-1:0];
        STEP_QX:  n2_q <= acc[NW-1:0];
        STEP_QY:  qx_q <= sx_neg_q ? (CW'(0) - quot) : quot;
        STEP_M0:  qy_q <= sy_neg_q ? (CW'(0) - quot) : quot;
        STEP_L0:  m_q  <= acc[pcs_pkg::M_W-1:0];
        STEP_R0:  l_q  <= acc[pcs_pkg::M_W-1:0];
        default: ;
      endcase
    end
    if (state_q == ST_DECIDE) begin
      smooth_q <= smooth_c;
    end
    if (state_q == ST_DONE && !eol_q) begin
      older_x_q <= held_x_q;
      older_y_q <= held_y_q;
      held_x_q  <= new_x_q;
      held_y_q  <= new_y_q;
    end
  end

  // ---------------------------------------------------------------------
  // result hand-off: interior point first, then the new point if it ends
  // the line (or starts one)
  // ---------------------------------------------------------------------
  assign push = ((state_q == ST_EMIT_A) || (state_q == ST_EMIT_B)) && !fifo_full;

  always_comb begin
    if (state_q == ST_EMIT_A) begin
      push_data.out_x        = smooth_q ? qx_q : held_x_q;
      push_data.out_y        = smooth_q ? qy_q : held_y_q;
      push_data.was_smoothed = smooth_q;
      push_data.last_of_line = 1'b0;
    end else begin
      push_data.out_x        = new_x_q;
      push_data.out_y        = new_y_q;
      push_data.was_smoothed = 1'b0;
      push_data.last_of_line = eol_q;
    end
  end

  `PCS_ASSERT_NEXT(a_first_point_emits, clk_i, rst_ni,
                   in_fire && seen_q == 2'd0, state_q == ST_EMIT_B,
                   "first point not emitted next")
  `PCS_ASSERT_NEXT(a_program_ends, clk_i, rst_ni,
                   state_q == ST_MUL && phase_q && step_q == STEP_LAST,
                   state_q == ST_DECIDE, "multiplier program overran")
  `PCS_ASSERT_NOW(a_smoothed_not_last, clk_i, rst_ni,
                  push && push_data.was_smoothed, !push_data.last_of_line,
                  "smoothed point flagged last")
  `PCS_ASSERT_NEXT(a_line_restarts, clk_i, rst_ni,
                   state_q == ST_DONE && eol_q, seen_q == 2'd0,
                   "polyline did not restart")

endmodule

`default_nettype wire
